[rtl/sha_pkg.sv]
// sha_pkg: constants and round functions for the sha-256 stream hasher
// no dependencies
package sha_pkg;

   localparam int WordWidth   = 32;
   localparam int BlockWords  = 16;
   localparam int ChainWords  = 8;
   localparam int Rounds      = 64;
   localparam logic [7:0] PadMark = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;

   function automatic logic [31:0] init_h(input logic [2:0] idx);
      logic [31:0] r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   typedef struct packed {
      logic start;
      logic busy;
   } cmp_ctl_type;

endpackage

[rtl/sha256_stream_hasher.sv]
// sha256_stream_hasher: byte stream in, sha-256 digest words out
// depends on sha_pkg and sha_compress
//
// usage: send message bytes on req_ (tdata[7:0] byte, tuser[0] byte valid,
// tlast ends the message). an item with tuser[0] low carries no byte; with
// tlast high it still closes the message. every byte is shifted into the
// block register; every 64th byte starts a 64-round
// compression, and req_tready stays low until it has finished and its
// result is folded into the chain. on tlast the block unit feeds padding
// bytes one per cycle, pausing while each of one or two more compressions
// runs, then gives eight digest words on rsp_ (tdata = word, tuser = index,
// tlast on index 7), one per cycle when rsp_tready is high. a stalled
// receiver holds the current word; no request is taken until all eight
// are delivered. throughput: one byte per cycle, taken only in the idle
// state. reset loads the initial hash values and clears counts and
// control; the block is ready once reset has set the idle state.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_valid
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // last_word
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_COMP = 5'b00010, ST_PAD = 5'b00100,
      ST_PCMP = 5'b01000, ST_OUT  = 5'b10000
   } state_type;

   state_type    st_ff, st_in;
   logic [511:0] blk_ff, blk_in;
   logic [255:0] h_ff, h_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [63:0]  len_ff, len_in;
   logic         fits_ff, fits_in;
   logic [2:0]   oidx_ff, oidx_in;
   logic         padded_ff, padded_in;
   logic         start;
   logic         cbusy, cdone;
   logic [255:0] csum, hinit;
   logic [7:0]   pbyte;
   sha_pkg::cmp_ctl_type ctl;
   logic [511:0] blk_words;

   always_comb begin
      for (int i = 0; i < 8; i++) hinit[i*32 +: 32] = sha_pkg::init_h(3'(i));
      // word 0 is the first 4 bytes shifted in, at the top of the block that includes
      // the byte going in this cycle
      for (int i = 0; i < 16; i++) blk_words[i*32 +: 32] = blk_in[(15-i)*32 +: 32];
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign start = ctl.start;

   always_comb begin
      // padding byte: mark, zeros, then length big-endian in the block it fits in
      if (!padded_ff) pbyte = sha_pkg::PadMark;
      else if (fits_ff && cnt_ff >= sha_pkg::LenPos)
         pbyte = len_ff[(7 - cnt_ff[2:0])*8 +: 8];
      else pbyte = 8'h00;
   end

   always_comb begin
      st_in = st_ff; blk_in = blk_ff; h_in = h_ff; cnt_in = cnt_ff;
      len_in = len_ff; fits_in = fits_ff; oidx_in = oidx_ff;
      padded_in = padded_ff; ctl = '0; ctl.busy = cbusy;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  blk_in = {blk_ff[503:0], req_tdata};
                  cnt_in = cnt_ff + 6'd1;
                  len_in = len_ff + 64'd8;
               end
               padded_in = 1'b0;
               fits_in = 1'b0;
               if (req_tuser && cnt_ff == 6'd63) begin
                  ctl.start = 1'b1;
                  st_in = req_tlast ? ST_PCMP : ST_COMP;
               end else if (req_tlast) st_in = ST_PAD;
            end
         end
         ST_COMP: if (cdone) begin h_in = csum; st_in = ST_IDLE; end
         ST_PAD: begin
            blk_in = {blk_ff[503:0], pbyte};
            cnt_in = cnt_ff + 6'd1;
            padded_in = 1'b1;
            // length field fits behind the mark in this block
            if (!padded_ff && cnt_ff < sha_pkg::LenPos) fits_in = 1'b1;
            if (cnt_ff == 6'd63) begin
               ctl.start = 1'b1; st_in = ST_PCMP;
            end
         end
         ST_PCMP: if (cdone) begin
            h_in = csum;
            // done once the length field went out
            if (fits_ff && cnt_ff == 6'd0) begin
               st_in = ST_OUT; oidx_in = '0;
            end else begin
               if (padded_ff) fits_in = 1'b1;
               st_in = ST_PAD;
            end
         end
         ST_OUT: if (rsp_tready) begin
            oidx_in = oidx_ff + 3'd1;
            if (oidx_ff == 3'd7) begin
               st_in = ST_IDLE; h_in = hinit; len_in = '0; cnt_in = '0;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (reset) begin
         st_ff <= ST_IDLE; h_ff <= hinit; cnt_ff <= '0; len_ff <= '0;
         oidx_ff <= '0; padded_ff <= 1'b0; fits_ff <= 1'b0;
      end else begin
         st_ff <= st_in; h_ff <= h_in; cnt_ff <= cnt_in; len_ff <= len_in;
         oidx_ff <= oidx_in; padded_ff <= padded_in; fits_ff <= fits_in;
      end
   end

   sha_compress u_cmp (
      .clock(clock), .reset(reset), .start(start), .block(blk_words),
      .chain(h_ff), .busy(cbusy), .done(cdone), .sum(csum)
   );

   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tdata  = h_ff[oidx_ff*32 +: 32];
   assign rsp_tuser  = oidx_ff;
   assign rsp_tlast  = (oidx_ff == 3'd7);

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cbusy |-> !req_tready) else $error("request taken during compression");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tuser))
      else $error("digest word dropped");
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !ctl.busy) else $error("compression restarted while busy");
endmodule

[rtl/sha_compress.sv]
// sha_compress: one sha-256 round per cycle over a 16-word rolling schedule
// depends on sha_pkg
module sha_compress (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [16*32-1:0]         block,
   input  logic [8*32-1:0]          chain,
   output logic                     busy,
   output logic                     done,
   output logic [8*32-1:0]          sum
);
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [5:0]  t_ff, t_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] s0, s1, wn, big0, big1, ch, maj, tmp1, tmp2;

   always_comb begin
      s0 = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = s1 + w_ff[9] + s0 + w_ff[0];
      big1 = sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11) ^ sha_pkg::rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      tmp1 = v_ff[7] + big1 + ch + sha_pkg::round_k(t_ff) + w_ff[0];
      big0 = sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13) ^ sha_pkg::rotr(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      tmp2 = big0 + maj;
      w_in = w_ff; v_in = v_ff;
      t_in = t_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         for (int i = 0; i < 16; i++) w_in[i] = block[i*32 +: 32];
         for (int i = 0; i < 8; i++)  v_in[i] = chain[i*32 +: 32];
         t_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         // schedule window slides by one word each round
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wn;
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + tmp1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = tmp1 + tmp2;
         t_in = t_ff + 6'd1;
         if (t_ff == 6'd63) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      t_ff <= t_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) sum[i*32 +: 32] = chain[i*32 +: 32] + v_ff[i];
   end
   assign busy = busy_ff;
   assign done = done_ff;
endmodule

[dv/sha256_stream_checker.sv]
// sha256_stream_checker: watches the request and digest channels of the hasher,
// predicts each digest with its own sha-256 model and compares word by word
// depends on nothing but the channel signals
module sha256_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // byte_valid
   input  logic        req_tlast,   // is_last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // digest_word
   input  logic [2:0]  rsp_tuser,   // word_index
   input  logic        rsp_tlast,   // last_word
   output int          fail_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [31:0] IvWords [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [31:0] KWords [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0]     hash_state [8];
   logic [31:0]     msg_block [16];
   logic [5:0]      block_fill;
   logic [63:0]     bit_length;
   digest_word_type digest_queue [$];

   assign pending_words = digest_queue.size();

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 64; t++) begin
         if (t < 16) w[t] = msg_block[t];
         else w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                   + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KWords[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      int sh;
      sh = (3 - block_fill[1:0]) * 8;
      if (block_fill[1:0] == 2'd0) msg_block[block_fill[5:2]] = 32'(b) << sh;
      else msg_block[block_fill[5:2]] |= 32'(b) << sh;
      if (block_fill == 6'd63) compress_block();
      block_fill = block_fill + 6'd1;
   endtask

   task automatic predict_request(input logic [7:0] b, input logic valid, input logic last);
      logic [63:0] len;
      digest_word_type d;
      if (valid) begin
         absorb_byte(b);
         bit_length += 64'd8;
      end
      if (last) begin
         len = bit_length;
         absorb_byte(8'h80);
         while (block_fill != 6'd56) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8*i -: 8]);
         for (int i = 0; i < 8; i++) begin
            d.word = hash_state[i];
            d.index = 3'(i);
            d.last = (i == 7);
            digest_queue.push_back(d);
         end
         hash_state = IvWords;
         block_fill = '0;
         bit_length = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      digest_word_type e;
      if (reset) begin
         hash_state = IvWords;
         block_fill = '0;
         bit_length = '0;
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) predict_request(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) report_mismatch("unexpected word", rsp_tdata, 0);
            else begin
               e = digest_queue.pop_front();
               if (rsp_tdata !== e.word) report_mismatch("digest_word", rsp_tdata, e.word);
               if (rsp_tuser !== e.index)
                  report_mismatch("word_index", 32'(rsp_tuser), 32'(e.index));
               if (rsp_tlast !== e.last)
                  report_mismatch("last_word", 32'(rsp_tlast), 32'(e.last));
            end
         end
      end
   end
endmodule

[dv/tb_sha256_stream_hasher.sv]
// tb_sha256_stream_hasher: drives directed messages and messages of random length and content into the
// hasher with random gaps and stalls; depends on sha256_stream_checker and the rtl
module tb_sha256_stream_hasher;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tuser = 0, req_tlast = 0;
   logic [7:0]  req_tdata = 0;
   logic        req_tready, rsp_tvalid, rsp_tlast;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   int          fail_count, pending_words;
   int          cycle_count = 0;
   bit          stall_free = 0;

   always #5 clock = ~clock;

   sha256_stream_hasher dut (.*);
   sha256_stream_checker checker_i (.*);

   function automatic int gap_length();
      if (stall_free) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      if ($urandom_range(1) == 0) return 0;
      return $urandom_range(3);
   endfunction

   // entered at a falling edge; leaves the request up, end_burst drops it
   task automatic send_request(input logic [7:0] b, input logic valid, input logic last);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= valid;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      req_tdata <= 8'($urandom);
   endtask

   task automatic send_message(input int len, input bit empty_close);
      for (int i = 0; i < len; i++) begin
         // sprinkle idle requests and ignored data bytes
         if ($urandom_range(15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
         send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_close);
      end
      if (empty_close || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("sha256_stream_hasher regression: fail");
         $finish;
      end
   end

   // receiver stalls
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         gap = gap_length();
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
      end
   end

   initial begin
      int n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty message, extreme bytes, padding boundaries
      send_request(8'hff, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'h5a, 1'b0, 1'b0);
      send_message(3, 0);
      send_message(2, 1);
      end_burst();
      wait (pending_words == 0);
      @(negedge clock);
      stall_free = 1;
      send_message(55, 0);
      stall_free = 0;
      send_message(56, 0);
      send_message(64, 1);
      send_message(63, 0);
      end_burst();
      // hold off until every digest is out
      wait (pending_words == 0);
      repeat (20) @(negedge clock);
      n = 0;
      while (n < 80) begin
         int len;
         len = ($urandom_range(7) == 0) ? $urandom_range(130, 50) : $urandom_range(12);
         send_message(len, $urandom_range(3) == 0);
         n += len + 1;
      end
      end_burst();
      wait (pending_words == 0);
      repeat (200) @(negedge clock);
      if (fail_count == 0) $display("sha256_stream_hasher regression: pass");
      else $display("sha256_stream_hasher regression: fail");
      $finish;
   end
endmodule
